@@ hdl/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, state type and round functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned BLK_WORDS  = 16;
    localparam int unsigned ROUNDS     = 64;
    localparam int unsigned CHAIN_N    = 8;
    localparam int unsigned CNT_W      = 61;

    typedef enum logic [2:0] {
        t_ST_LOAD,
        t_ST_CLEAR,
        t_ST_PRIME,
        t_ST_ROUND,
        t_ST_FOLD,
        t_ST_PAD,
        t_ST_OUT
    } t_state;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] h;
        unique case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ hdl/sha256_ram.sv @@
// ----------------------------------------------------------------------------
// SHA-256 generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sha256_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/sha256_message_digest.sv @@
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Byte-streaming SHA-256 engine with the message schedule in a RAM.
// ----------------------------------------------------------------------------
// Usage: message bytes enter on the s_axis channel, one word per cycle while
// a block fills. tdata[7:0] is the byte, tuser[0] marks a valid byte and
// tlast closes the message. A word with tuser[0] low and tlast high is an
// empty tail. Bytes are packed big-endian into 32-bit schedule words that are
// written straight into a 16-entry schedule RAM. When the 64th byte of a
// block arrives, s_axis_tready drops through a RAM priming step, 64 rounds
// (one per cycle, the RAM read port feeding the next round) and a fold
// step into the chaining value. On tlast the block sweeps the rest of the
// block at one pad byte per cycle and compresses it, with a second padded
// block when the length does not fit. The digest is presented as one
// 256-bit word on m_axis with tlast high; the input stays stalled until the
// digest word is taken, so a stalled receiver simply holds the engine.
// Reset loads the initial hash values and clears the byte count; RAM
// contents are undefined until written and need no clearing.
// ----------------------------------------------------------------------------
module sha256_message_digest
    import sha256_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] has_byte
    input  logic         s_axis_tlast,   // is_last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] digest_word0, [127:64] digest_word1, [191:128] digest_word2,
    // [255:192] digest_word3
    output logic [255:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    t_state            r_state, n_state;
    logic [31:0]       r_h [CHAIN_N];
    logic [31:0]       r_v [CHAIN_N];
    logic [31:0]       r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic [6:0]        r_rnd;       // round index, also pad position
    logic              r_fin;       // message closed, padding pending
    logic              r_lenok;     // final block with length is in the RAM
    logic              r_mark;      // 0x80 already placed
    logic [31:0]       r_sh [BLK_WORDS]; // rolling window for s0/s1 taps

    logic              ram_we;
    logic [3:0]        ram_waddr, ram_raddr;
    logic [31:0]       ram_wdata, ram_rdata;

    sha256_ram #(.WIDTH(32), .DEPTH(BLK_WORDS)) u_sched (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    logic        acc_in;
    logic [5:0]  pos;
    logic [31:0] acc_nx;
    logic [31:0] s0, s1, wn, t1, t2, ch, mj, e1, a0;
    logic [63:0] bits;

    assign acc_in = s_axis_tvalid && s_axis_tready;
    assign pos    = r_cnt[5:0];
    assign bits   = {r_cnt, 3'b000};
    assign acc_nx = {r_acc[23:0], s_axis_tdata};

    // Schedule expansion from the register window; window slot 0 is W[t-16].
    assign s1 = rotr(r_sh[14], 17) ^ rotr(r_sh[14], 19) ^ (r_sh[14] >> 10);
    assign s0 = rotr(r_sh[1], 7) ^ rotr(r_sh[1], 18) ^ (r_sh[1] >> 3);
    assign wn = (r_rnd < 7'd16) ? ram_rdata : s1 + r_sh[9] + s0 + r_sh[0];

    assign e1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
    assign ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign a0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
    assign mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1 = r_v[7] + e1 + ch + round_k(r_rnd[5:0]) + wn;
    assign t2 = a0 + mj;

    // Byte in the padding sweep: 0x80 at the message end, zeros elsewhere.
    function automatic logic [7:0] pad_byte(input logic [5:0] p);
        return (p == r_cnt[5:0] && !r_mark) ? 8'h80 : 8'h00;
    endfunction

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_ST_LOAD: begin
                if (acc_in) begin
                    if (s_axis_tuser && pos == 6'd63) begin
                        n_state = t_ST_PRIME;
                    end else if (s_axis_tlast) begin
                        n_state = t_ST_PAD;
                    end
                end
            end
            t_ST_PAD: begin
                if (r_rnd[5:0] == 6'd63 || (r_lenok && r_rnd[5:0] == 6'd63)) begin
                    n_state = t_ST_PRIME;
                end
            end
            t_ST_CLEAR: n_state = t_ST_PRIME;
            t_ST_PRIME: n_state = t_ST_ROUND;
            t_ST_ROUND: if (r_rnd == 7'd63) n_state = t_ST_FOLD;
            t_ST_FOLD: begin
                if (r_fin && r_lenok) n_state = t_ST_OUT;
                else if (r_fin) n_state = t_ST_PAD;
                else n_state = t_ST_LOAD;
            end
            t_ST_OUT: if (m_axis_tready) n_state = t_ST_LOAD;
            default: n_state = t_ST_LOAD;
        endcase
    end

    // Outputs and RAM port control.
    always_comb begin
        s_axis_tready = (r_state == t_ST_LOAD);
        m_axis_tvalid = (r_state == t_ST_OUT);
        m_axis_tlast  = 1'b1;
        m_axis_tdata  = {r_h[6], r_h[7], r_h[4], r_h[5], r_h[2], r_h[3], r_h[0], r_h[1]};
        ram_we    = 1'b0;
        ram_waddr = pos[5:2];
        ram_wdata = acc_nx;
        ram_raddr = r_rnd[3:0];
        unique case (r_state)
            t_ST_LOAD: begin
                ram_we = acc_in && s_axis_tuser && pos[1:0] == 2'd3;
                ram_raddr = 4'd0;
            end
            t_ST_PAD: begin
                // One byte position per cycle; the word is committed at byte 3.
                ram_waddr = r_rnd[5:2];
                ram_we    = (r_rnd[1:0] == 2'd3);
                if (r_lenok && r_rnd[5:2] == 4'd14) ram_wdata = bits[63:32];
                else if (r_lenok && r_rnd[5:2] == 4'd15) ram_wdata = bits[31:0];
                else ram_wdata = {r_acc[23:0], pad_byte(r_rnd[5:0])};
                ram_raddr = 4'd0;
            end
            t_ST_PRIME: ram_raddr = 4'd0;
            t_ST_ROUND: ram_raddr = r_rnd[3:0] + 4'd1;
            default: ram_raddr = 4'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_LOAD;
            r_cnt   <= '0;
            r_fin   <= 1'b0;
            r_lenok <= 1'b0;
            r_mark  <= 1'b0;
            r_rnd   <= '0;
            for (int i = 0; i < CHAIN_N; i++) r_h[i] <= init_h(3'(i));
        end else begin
            r_state <= n_state;
            unique case (r_state)
                t_ST_LOAD: begin
                    if (acc_in) begin
                        if (s_axis_tuser) begin
                            r_acc <= acc_nx;
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_fin  <= 1'b1;
                            r_mark <= 1'b0;
                            // Padding restarts at the next free byte.
                            r_rnd  <= {1'b0, r_cnt[5:0] + 6'(s_axis_tuser)};
                            // A block completed by the last byte still needs a
                            // whole padding block after it is folded.
                            r_lenok <= ((r_cnt[5:0] + 6'(s_axis_tuser)) < 6'd56)
                                       && !(s_axis_tuser && pos == 6'd63);
                        end
                        if (s_axis_tuser && pos == 6'd63) begin
                            r_rnd <= '0;
                            for (int i = 0; i < CHAIN_N; i++) r_v[i] <= r_h[i];
                        end
                    end
                end
                t_ST_PAD: begin
                    r_acc <= {r_acc[23:0], pad_byte(r_rnd[5:0])};
                    if (r_rnd[5:0] == r_cnt[5:0]) r_mark <= 1'b1;
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd[5:0] == 6'd63) begin
                        r_rnd <= '0;
                        for (int i = 0; i < CHAIN_N; i++) r_v[i] <= r_h[i];
                    end
                end
                t_ST_PRIME: begin
                    r_rnd <= '0;
                end
                t_ST_ROUND: begin
                    for (int i = 0; i < BLK_WORDS - 1; i++) r_sh[i] <= r_sh[i+1];
                    r_sh[BLK_WORDS-1] <= wn;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd  <= r_rnd + 1'b1;
                end
                t_ST_FOLD: begin
                    for (int i = 0; i < CHAIN_N; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_rnd <= '0;
                    if (r_fin && !r_lenok) begin
                        r_lenok <= 1'b1;
                        r_rnd   <= '0;
                    end
                    if (!r_fin && r_lenok) r_lenok <= 1'b0;
                end
                t_ST_OUT: begin
                    if (m_axis_tready) begin
                        for (int i = 0; i < CHAIN_N; i++) r_h[i] <= init_h(3'(i));
                        r_cnt   <= '0;
                        r_fin   <= 1'b0;
                        r_lenok <= 1'b0;
                        r_mark  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

@@ hdl/sha256_checker.sv @@
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Port-level checks on the digest engine, bound to the top level.
// ----------------------------------------------------------------------------
module sha256_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [255:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    // A pending digest word holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest changed while stalled");

    // The engine never takes input while a digest is pending.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input open while digest pending");

    // Every digest word ends a frame.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tlast)
        else $error("digest without tlast");

    // Nothing is pending right after reset.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("digest valid after reset");
endmodule

bind sha256_message_digest sha256_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

@@ bench/tb_sha256_message_digest.sv @@
// ----------------------------------------------------------------------------
// SHA-256 message digest testbench
// Streams messages of varied length into the digest engine with random gaps
// on both sides and checks every digest word against a behavioral SHA-256.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sha256_message_digest;
    import sha256_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } byte_word_t;

    typedef struct packed {
        logic [63:0] w3;
        logic [63:0] w2;
        logic [63:0] w1;
        logic [63:0] w0;
    } digest_t;

    localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
        32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] KR [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // [7:0] data_byte
    logic         s_axis_tuser;   // [0] has_byte
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [255:0] m_axis_tdata;   // [63:0] word0 .. [255:192] word3
    logic         m_axis_tlast;

    sha256_message_digest i_dut (.*);

    // Predictor state.
    logic [31:0] hash_chain [8];
    logic [7:0]  msg_block [64];
    logic [60:0] msg_bytes;

    byte_word_t pending_words [$];
    digest_t    expected_digests [$];
    int         n_errors;
    int         n_digests;
    int         n_words;
    bit         hold_off;       // long receiver stall in progress
    bit         in_fire;        // input handshake seen at the last rising edge
    bit         out_fire;       // output handshake seen at the last rising edge

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, x2, x15;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        v = hash_chain;
        for (int t = 0; t < 64; t++) begin
            if (t >= 16) begin
                x2  = w[(t - 2) & 15];
                x15 = w[(t - 15) & 15];
                s1 = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
                s0 = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
                w[t & 15] = s1 + w[(t - 7) & 15] + s0 + w[t & 15];
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KR[t] + w[t & 15];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++) hash_chain[t] += v[t];
    endtask

    task automatic digest_step(byte_word_t wd);
        int pos;
        logic [63:0] bits;
        digest_t d;
        if (wd.has_byte) begin
            pos = msg_bytes[5:0];
            msg_block[pos] = wd.data_byte;
            msg_bytes = msg_bytes + 1;
            if (pos == 63) compress_block();
        end
        if (wd.is_last) begin
            pos = msg_bytes[5:0];
            msg_block[pos] = 8'h80;
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin
                    msg_block[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < 56) begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            bits = {msg_bytes, 3'b000};
            for (int i = 0; i < 8; i++) msg_block[63 - i] = bits[8*i +: 8];
            compress_block();
            d.w0 = {hash_chain[0], hash_chain[1]};
            d.w1 = {hash_chain[2], hash_chain[3]};
            d.w2 = {hash_chain[4], hash_chain[5]};
            d.w3 = {hash_chain[6], hash_chain[7]};
            expected_digests.push_back(d);
            hash_chain = IV;
            msg_bytes = '0;
        end
    endtask

    task automatic queue_message(int len, bit with_noise, bit last_carries_byte);
        byte_word_t wd;
        for (int i = 0; i < len; i++) begin
            if (with_noise && $urandom_range(0, 15) == 0)
                pending_words.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
            wd = '{8'($urandom_range(0, 255)), 1'b1, 1'b0};
            if (i == len - 1 && last_carries_byte) wd.is_last = 1'b1;
            pending_words.push_back(wd);
        end
        if (len == 0 || !last_carries_byte)
            pending_words.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b1});
    endtask

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // Handshakes are taken at the rising edge, where the block accepts.
    always @(posedge i_clk) begin
        in_fire  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
    end

    // Driver: draws a gap per word, then offers it until accepted.
    int send_gap;
    byte_word_t cur_word;
    bit have_word;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            have_word = 0;
            send_gap = 0;
        end else begin
            if (in_fire) begin
                digest_step(cur_word);
                n_words++;
                have_word = 0;
            end
            if (!have_word && pending_words.size() > 0) begin
                cur_word = pending_words.pop_front();
                have_word = 1;
                send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            end
            if (have_word && send_gap == 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= cur_word.data_byte;
                s_axis_tuser  <= cur_word.has_byte;
                s_axis_tlast  <= cur_word.is_last;
            end else begin
                s_axis_tvalid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end
        end
    end

    // Receiver side: random stalls plus an optional long hold-off.
    int recv_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (out_fire)
                recv_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor.
    digest_t got, exp_d;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_digests.size() == 0) begin
                $error("digest with none expected: %h", m_axis_tdata);
                n_errors++;
            end else begin
                exp_d = expected_digests.pop_front();
                n_digests++;
                if (got.w0 !== exp_d.w0) begin
                    $error("digest_word0 exp %h got %h", exp_d.w0, got.w0); n_errors++;
                end
                if (got.w1 !== exp_d.w1) begin
                    $error("digest_word1 exp %h got %h", exp_d.w1, got.w1); n_errors++;
                end
                if (got.w2 !== exp_d.w2) begin
                    $error("digest_word2 exp %h got %h", exp_d.w2, got.w2); n_errors++;
                end
                if (got.w3 !== exp_d.w3) begin
                    $error("digest_word3 exp %h got %h", exp_d.w3, got.w3); n_errors++;
                end
                if (m_axis_tlast !== 1'b1) begin
                    $error("tlast exp 1 got %b", m_axis_tlast); n_errors++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb_sha256_message_digest: done, errors");
        $finish;
    end

    initial begin
        int len;
        hash_chain = IV;
        msg_bytes = '0;
        n_errors = 0; n_digests = 0; n_words = 0;
        hold_off = 1'b0;
        in_fire = 1'b0; out_fire = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0; m_axis_tready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // Directed: empty message, noise word, extreme bytes, byte on last,
        // the one-block limit of 55 bytes, the two-block pad from 56 up and
        // a full block closed both by its own last byte and by an empty tail.
        pending_words.push_back('{8'hff, 1'b0, 1'b0});
        pending_words.push_back('{8'hff, 1'b0, 1'b1});
        pending_words.push_back('{8'h00, 1'b1, 1'b0});
        pending_words.push_back('{8'hff, 1'b1, 1'b1});
        pending_words.push_back('{8'h55, 1'b1, 1'b0});
        pending_words.push_back('{8'haa, 1'b1, 1'b0});
        pending_words.push_back('{8'h00, 1'b0, 1'b1});
        queue_message(55, 0, 1);
        queue_message(56, 0, 1);
        queue_message(64, 0, 0);
        queue_message(64, 0, 1);
        queue_message(128, 0, 1);
        wait (pending_words.size() == 0 && !have_word && expected_digests.size() == 0);

        // Long receiver hold-off while messages keep coming.
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(negedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        for (int m = 0; m < 4; m++) queue_message($urandom_range(0, 10), 0, 1);
        wait (pending_words.size() == 0 && !have_word && expected_digests.size() == 0);

        while (n_words < 1650) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 140)
                                              : $urandom_range(0, 20);
            queue_message(len, 1, 1'($urandom_range(0, 1)));
            wait (pending_words.size() == 0);
            if ($urandom_range(0, 7) == 0)
                wait (!have_word && expected_digests.size() == 0);
        end
        wait (pending_words.size() == 0 && !have_word && expected_digests.size() == 0);
        repeat (300) @(posedge i_clk);
        $display("Ran %0d input words and checked %0d digests, lengths 0 to 140 bytes.",
                 n_words, n_digests);
        if (n_errors == 0) begin
            $display("tb_sha256_message_digest: done, clean");
        end else begin
            $display("tb_sha256_message_digest: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/sha256_pkg.sv
hdl/sha256_ram.sv
hdl/sha256_message_digest.sv
hdl/sha256_checker.sv
bench/tb_sha256_message_digest.sv
